[hdl/keyboard_matrix_key_translator_macros.svh]
`ifndef KEYBOARD_MATRIX_KEY_TRANSLATOR_MACROS_SVH
`define KEYBOARD_MATRIX_KEY_TRANSLATOR_MACROS_SVH
`ifndef ASSERT_OFF
`define KMKT_ASSERT_ALWAYS(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("invariant check failed");
`define KMKT_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");
`define KMKT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define KMKT_ASSERT_ALWAYS(label, clk, rstn, prop)
`define KMKT_ASSERT_IMP(label, clk, rstn, ante, cons)
`define KMKT_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

[hdl/kmkt_pkg.sv]
package kmkt_pkg;

    localparam int NUM_POS    = 70;
    localparam int NUM_SLOTS  = 8;
    localparam int POS_W      = 7;
    localparam int SLOT_W     = 11;
    localparam int USED_W     = 4;
    localparam int ENTRY_W    = 14;
    localparam int TBL_W      = 2;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 96;
    localparam int CNT_LSB    = NUM_SLOTS * SLOT_W;

    localparam logic [POS_W-1:0] POS_LSHIFT = 7'd43;
    localparam logic [POS_W-1:0] POS_SYM    = 7'd42;
    localparam logic [POS_W-1:0] POS_CBM    = 7'd28;
    localparam logic [POS_W-1:0] POS_CTRL   = 7'd56;
    localparam logic [POS_W-1:0] LAST_POS   = 7'd69;

    localparam logic [ENTRY_W-1:0] ENTRY_EMPTY   = 14'd88;
    localparam logic [ENTRY_W-1:0] ENTRY_RESTORE = 14'd1024;
    localparam int FLAG_SHIFT_BIT   = 11;
    localparam int FLAG_NOSHIFT_BIT = 12;
    localparam int FLAG_CBM_BIT     = 13;

    localparam logic [SLOT_W-1:0] CODE_MASK       = 11'h5ff;
    localparam logic [SLOT_W-1:0] KEY_EMPTY       = 11'd88;
    localparam logic [SLOT_W-1:0] CODE_SHIFT      = 11'd15;
    localparam logic [SLOT_W-1:0] CODE_COMMODORE  = 11'd61;
    localparam logic [SLOT_W-1:0] CODE_CTRL_EXTRA = 11'd63;
    localparam logic [USED_W-1:0] SLOT_COUNT      = 4'd8;

    typedef enum logic [TBL_W-1:0] {
        TBL_PLAIN = 2'd0,
        TBL_SHIFT = 2'd1,
        TBL_SYM   = 2'd2
    } tbl_t;

    typedef struct packed {
        logic             start;
        logic             rd_en;
        logic [POS_W-1:0] rd_pos;
        logic             out_load;
    } cmd_t;

    typedef struct packed {
        logic full;
    } status_t;

    localparam logic [ENTRY_W-1:0] ROM_PLAIN [NUM_POS] = '{
        14'd63, 14'd56, 14'd59, 14'd8, 14'd11, 14'd16, 14'd19, 14'd24, 14'd27, 14'd32,
        14'd35, 14'd43, 14'd40, 14'd0,
        14'd8209, 14'd2104, 14'd46, 14'd2056, 14'd2059, 14'd2064, 14'd54, 14'd2067,
        14'd49, 14'd2075, 14'd2080, 14'd2093, 14'd2098, 14'd48,
        14'd61, 14'd62, 14'd9, 14'd14, 14'd17, 14'd22, 14'd25, 14'd30, 14'd33, 14'd38,
        14'd41, 14'd50, 14'd2072, 14'd0,
        14'd88, 14'd15, 14'd10, 14'd13, 14'd18, 14'd21, 14'd26, 14'd29, 14'd34, 14'd37,
        14'd42, 14'd83, 14'd57, 14'd1,
        14'd58, 14'd80, 14'd12, 14'd23, 14'd20, 14'd31, 14'd28, 14'd39, 14'd36, 14'd44,
        14'd85, 14'd84, 14'd86, 14'd60
    };

    localparam logic [ENTRY_W-1:0] ROM_SHIFT [NUM_POS] = '{
        14'd63, 14'd56, 14'd4142, 14'd8, 14'd11, 14'd16, 14'd4150, 14'd19, 14'd4145,
        14'd27, 14'd32, 14'd4153, 14'd4149, 14'd0,
        14'd12302, 14'd55, 14'd4142, 14'd8, 14'd11, 14'd16, 14'd54, 14'd19, 14'd4151,
        14'd47, 14'd44, 14'd12350, 14'd12297, 14'd2091,
        14'd61, 14'd62, 14'd9, 14'd14, 14'd17, 14'd22, 14'd25, 14'd30, 14'd33, 14'd38,
        14'd41, 14'd4141, 14'd59, 14'd0,
        14'd88, 14'd15, 14'd10, 14'd13, 14'd18, 14'd21, 14'd26, 14'd29, 14'd34, 14'd37,
        14'd42, 14'd4179, 14'd4149, 14'd1,
        14'd58, 14'd80, 14'd12, 14'd23, 14'd20, 14'd31, 14'd28, 14'd39, 14'd36, 14'd4143,
        14'd4181, 14'd4180, 14'd4182, 14'd60
    };

    localparam logic [ENTRY_W-1:0] ROM_SYM [NUM_POS] = '{
        14'd72, 14'd4, 14'd2052, 14'd5, 14'd2053, 14'd6, 14'd2054, 14'd3, 14'd2051,
        14'd88, 14'd88, 14'd88, 14'd51, 14'd1024,
        14'd8206, 14'd2103, 14'd88, 14'd88, 14'd88, 14'd88, 14'd88, 14'd88, 14'd55,
        14'd2095, 14'd2092, 14'd8254, 14'd8201, 14'd2091,
        14'd67, 14'd88, 14'd88, 14'd88, 14'd88, 14'd88, 14'd88, 14'd88, 14'd88, 14'd88,
        14'd88, 14'd45, 14'd2107, 14'd88,
        14'd88, 14'd15, 14'd88, 14'd88, 14'd88, 14'd88, 14'd88, 14'd88, 14'd88, 14'd88,
        14'd88, 14'd88, 14'd53, 14'd88,
        14'd88, 14'd88, 14'd88, 14'd88, 14'd88, 14'd88, 14'd88, 14'd88, 14'd88, 14'd47,
        14'd88, 14'd88, 14'd88, 14'd88
    };

    function automatic logic [ENTRY_W-1:0] rom_entry(input tbl_t tbl,
                                                     input logic [POS_W-1:0] pos);
        logic [ENTRY_W-1:0] e;
        case (tbl)
            TBL_PLAIN: e = ROM_PLAIN[pos];
            TBL_SHIFT: e = ROM_SHIFT[pos];
            TBL_SYM:   e = ROM_SYM[pos];
            default:   e = ENTRY_EMPTY;
        endcase
        return e;
    endfunction

endpackage

[hdl/kmkt_ctrl.sv]
`include "keyboard_matrix_key_translator_macros.svh"

module kmkt_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  kmkt_pkg::status_t status,
    output kmkt_pkg::cmd_t   cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_FLUSH  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t                       state_reg, state_next;
    logic [kmkt_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        cmd            = '0;
        cmd.rd_pos     = pos_reg;
        out_valid_next = out_valid_reg & ~m_tready;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.start  = 1'b1;
                    pos_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status.full) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.rd_en = 1'b1;
                    if (pos_reg == kmkt_pkg::LAST_POS) begin
                        state_next = ST_FLUSH;
                    end else begin
                        pos_next = pos_reg + 7'd1;
                    end
                end
            end
            ST_FLUSH: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `KMKT_ASSERT_NEXT(a_start_scan, aclk, aresetn, accept, state_reg == ST_SCAN && pos_reg == 7'd0)
    `KMKT_ASSERT_IMP(a_flush_last, aclk, aresetn, state_reg == ST_FLUSH, $past(pos_reg) == kmkt_pkg::LAST_POS)
    `KMKT_ASSERT_IMP(a_load_finish, aclk, aresetn, cmd.out_load, state_reg == ST_FINISH)
    `KMKT_ASSERT_NEXT(a_load_valid, aclk, aresetn, cmd.out_load, m_tvalid && state_reg == ST_IDLE)

endmodule

[hdl/kmkt_dp.sv]
`include "keyboard_matrix_key_translator_macros.svh"

module kmkt_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [63:0]                    pressed_low,
    input  logic [5:0]                     pressed_high,
    input  kmkt_pkg::cmd_t                 cmd,
    output kmkt_pkg::status_t              status,
    output logic [kmkt_pkg::M_TDATA_W-1:0] m_data
);

    logic [kmkt_pkg::NUM_POS-1:0]   pressed_reg;
    logic                           shift_on_reg, cbm_on_reg, ctrl_on_reg;
    kmkt_pkg::tbl_t                 tbl_reg;
    logic [kmkt_pkg::ENTRY_W-1:0]   e_reg;
    logic                           act_reg;
    logic                           e_valid_reg;
    logic [kmkt_pkg::SLOT_W-1:0]    slot_reg  [kmkt_pkg::NUM_SLOTS];
    logic [kmkt_pkg::SLOT_W-1:0]    slot_next [kmkt_pkg::NUM_SLOTS];
    logic [kmkt_pkg::USED_W-1:0]    used_reg, used_next;
    logic                           did_shift_reg, did_shift_next;
    logic                           did_noshift_reg, did_noshift_next;
    logic                           did_cbm_reg, did_cbm_next;
    logic [kmkt_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic [kmkt_pkg::NUM_POS-1:0]   pressed_in;

    assign pressed_in  = {pressed_high, pressed_low};
    assign status.full = used_reg[kmkt_pkg::USED_W-1];
    assign m_data      = m_data_reg;

    always_comb begin
        logic [kmkt_pkg::SLOT_W-1:0] s [kmkt_pkg::NUM_SLOTS];
        logic [kmkt_pkg::USED_W-1:0] u;
        logic                        ds, dn, dc, skip;
        logic [kmkt_pkg::SLOT_W-1:0] code;
        s    = slot_reg;
        u    = used_reg;
        ds   = did_shift_reg;
        dn   = did_noshift_reg;
        dc   = did_cbm_reg;
        skip = 1'b0;
        code = e_reg[kmkt_pkg::SLOT_W-1:0] & kmkt_pkg::CODE_MASK;
        if (e_valid_reg && act_reg && e_reg != kmkt_pkg::ENTRY_EMPTY && !u[3]) begin
            if (e_reg[kmkt_pkg::FLAG_SHIFT_BIT] && !shift_on_reg && !ds) begin
                if (u > 4'd6) begin
                    skip = 1'b1;
                end else begin
                    ds = 1'b1;
                    for (int k = kmkt_pkg::NUM_SLOTS - 1; k > 0; k--) begin
                        s[k] = s[k-1];
                    end
                    s[0] = kmkt_pkg::CODE_SHIFT;
                    u    = u + 4'd1;
                end
            end
            if (!skip && e_reg[kmkt_pkg::FLAG_NOSHIFT_BIT] && !dn && shift_on_reg) begin
                if (ds || u != 4'd1) begin
                    skip = 1'b1;
                end else begin
                    u  = '0;
                    dn = 1'b1;
                end
            end
            if (!skip && e_reg[kmkt_pkg::FLAG_CBM_BIT] && !dc && !cbm_on_reg) begin
                if (u > 4'd6) begin
                    skip = 1'b1;
                end else begin
                    dc = 1'b1;
                    for (int k = kmkt_pkg::NUM_SLOTS - 1; k > 0; k--) begin
                        s[k] = s[k-1];
                    end
                    s[0] = kmkt_pkg::CODE_COMMODORE;
                    u    = u + 4'd1;
                end
            end
            if (!skip) begin
                if (!u[3]) begin
                    s[u[2:0]] = code;
                    u         = u + 4'd1;
                end
                if (e_reg == kmkt_pkg::ENTRY_RESTORE && ctrl_on_reg && u == 4'd1) begin
                    s[u[2:0]] = kmkt_pkg::CODE_CTRL_EXTRA;
                    u         = u + 4'd1;
                end
            end
        end
        slot_next        = s;
        used_next        = u;
        did_shift_next   = ds;
        did_noshift_next = dn;
        did_cbm_next     = dc;
    end

    always_comb begin
        m_data_next = '0;
        for (int k = 0; k < kmkt_pkg::NUM_SLOTS; k++) begin
            m_data_next[k*kmkt_pkg::SLOT_W +: kmkt_pkg::SLOT_W] =
                (4'(k) < used_reg) ? slot_reg[k] : kmkt_pkg::KEY_EMPTY;
        end
        m_data_next[kmkt_pkg::CNT_LSB +: kmkt_pkg::USED_W] = kmkt_pkg::SLOT_COUNT;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg     <= 1'b0;
            used_reg        <= '0;
            did_shift_reg   <= 1'b0;
            did_noshift_reg <= 1'b0;
            did_cbm_reg     <= 1'b0;
            shift_on_reg    <= 1'b0;
            cbm_on_reg      <= 1'b0;
            ctrl_on_reg     <= 1'b0;
            tbl_reg         <= kmkt_pkg::TBL_PLAIN;
        end else begin
            e_valid_reg <= cmd.rd_en;
            if (cmd.start) begin
                shift_on_reg    <= pressed_in[kmkt_pkg::POS_LSHIFT];
                cbm_on_reg      <= pressed_in[kmkt_pkg::POS_CBM];
                ctrl_on_reg     <= pressed_in[kmkt_pkg::POS_CTRL];
                if (pressed_in[kmkt_pkg::POS_SYM]) begin
                    tbl_reg <= kmkt_pkg::TBL_SYM;
                end else if (pressed_in[kmkt_pkg::POS_LSHIFT]) begin
                    tbl_reg <= kmkt_pkg::TBL_SHIFT;
                end else begin
                    tbl_reg <= kmkt_pkg::TBL_PLAIN;
                end
                used_reg        <= {3'b000, pressed_in[kmkt_pkg::POS_LSHIFT]};
                did_shift_reg   <= 1'b0;
                did_noshift_reg <= 1'b0;
                did_cbm_reg     <= 1'b0;
            end else begin
                used_reg        <= used_next;
                did_shift_reg   <= did_shift_next;
                did_noshift_reg <= did_noshift_next;
                did_cbm_reg     <= did_cbm_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            pressed_reg <= pressed_in;
            slot_reg[0] <= kmkt_pkg::CODE_SHIFT;
        end else begin
            slot_reg <= slot_next;
        end
        if (cmd.rd_en) begin
            e_reg   <= kmkt_pkg::rom_entry(tbl_reg, cmd.rd_pos);
            act_reg <= pressed_reg[cmd.rd_pos] && (cmd.rd_pos != kmkt_pkg::POS_LSHIFT);
        end
        if (cmd.out_load) begin
            m_data_reg <= m_data_next;
        end
    end

    `KMKT_ASSERT_ALWAYS(a_used_range, aclk, aresetn, used_reg <= 4'd8)
    `KMKT_ASSERT_IMP(a_forced_shift_alone, aclk, aresetn, did_shift_reg, !shift_on_reg)
    `KMKT_ASSERT_IMP(a_noshift_real, aclk, aresetn, did_noshift_reg, shift_on_reg && !did_shift_reg)
    `KMKT_ASSERT_NEXT(a_start_clear, aclk, aresetn, cmd.start, !did_shift_reg && !did_noshift_reg && !did_cbm_reg)

endmodule

[hdl/keyboard_matrix_key_translator.sv]
// Keyboard matrix key translator.
// Input channel (s_): one request carries a 70-position pressed-key snapshot.
// Output channel (m_): one result per request, eight translated key codes
// (88 marks an empty slot) and a slot count that is always eight.
// A controller walks key positions 0 to 69, one per cycle, through the
// translation table; the datapath registers each table read and applies the
// forced shift, shift removal, forced commodore and restore rules in the
// following cycle. The walk ends early once all eight slots are filled.
// A new request is accepted only after the previous one is finished;
// s_tready is high only while no request is in translation.
// A finished result sits in the output register until taken; the next
// request is accepted meanwhile. If the receiver stalls with a result still
// pending, the block holds its new result until m_tready frees the register.
// Reset (aresetn low, synchronous) drops any request in flight and clears
// m_tvalid; no table initialization is needed afterward.
module keyboard_matrix_key_translator (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [63:0] pressed_low, [69:64] pressed_high, [71:70] zero
    input  logic [kmkt_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [10:0] key_slot_0 ... [87:77] key_slot_7, [91:88] slot_count, [95:92] zero
    output logic [kmkt_pkg::M_TDATA_W-1:0] m_tdata
);

    kmkt_pkg::cmd_t    cmd;
    kmkt_pkg::status_t status;
    logic [63:0]       pressed_low;
    logic [5:0]        pressed_high;

    assign pressed_low  = s_tdata[63:0];
    assign pressed_high = s_tdata[69:64];

    kmkt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    kmkt_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .pressed_low  (pressed_low),
        .pressed_high (pressed_high),
        .cmd          (cmd),
        .status       (status),
        .m_data       (m_tdata)
    );

endmodule
